>>> rtl/srs_pkg.sv
package srs_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 11;
	localparam int OP_W   = 2;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

	localparam logic [IDX_W-1:0] IDX_NONE = 11'h7FF;

	// controller -> datapath
	typedef struct packed {
		logic clear;
		logic append;
		logic load_key;
		logic init;      // lo = 0, hi = count - 1
		logic side;      // 0: first-index search, 1: last-index search
		logic probe;     // latch mid, RAM reads mid and its neighbor
		logic step;      // narrow the range
		logic rec_hit;
		logic rec_miss;
		logic load_out;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic run;       // lo <= hi
		logic hit;       // match at mid and it is the boundary
	} stat_t;

endpackage

>>> rtl/srs_ram.sv
module srs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                     rdata_a,
	output logic [WIDTH-1:0]                     rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

>>> rtl/srs_ctrl.sv
module srs_ctrl
	import srs_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [OP_W-1:0] op,
	output logic            out_valid,
	input  logic            out_ready,
	input  stat_t           stat,
	output cmd_t            cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CHK  = 2'd1;
	localparam logic [1:0] ST_CMP  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q, state_d;
	logic       side_q, side_d;
	logic       out_valid_q;

	always_comb begin
		cmd      = '0;
		cmd.side = side_q;
		state_d  = state_q;
		side_d   = side_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (op)
						OP_CLEAR:  cmd.clear = 1'b1;
						OP_APPEND: cmd.append = 1'b1;
						OP_QUERY: begin
							cmd.load_key = 1'b1;
							cmd.init     = 1'b1;
							side_d       = 1'b0;
							state_d      = ST_CHK;
						end
						default: ;
					endcase
				end
			end
			ST_CHK: begin
				if (stat.run) begin
					cmd.probe = 1'b1;
					state_d   = ST_CMP;
				end else begin
					cmd.rec_miss = 1'b1;
					if (!side_q) begin
						cmd.init = 1'b1;
						side_d   = 1'b1;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_CMP: begin
				if (stat.hit) begin
					cmd.rec_hit = 1'b1;
					if (!side_q) begin
						cmd.init = 1'b1;
						side_d   = 1'b1;
						state_d  = ST_CHK;
					end else begin
						state_d = ST_FIN;
					end
				end else begin
					cmd.step = 1'b1;
					state_d  = ST_CHK;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			side_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			side_q  <= side_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/srs_dpath.sv
module srs_dpath
	import srs_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output stat_t             stat,
	input  logic [DATA_W-1:0] value,
	output logic [IDX_W-1:0]  first_index,
	output logic [IDX_W-1:0]  last_index
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	logic [CW-1:0]     count_q;
	logic              full;
	logic [DATA_W-1:0] key_q;
	logic [SW-1:0]     lo_q, hi_q, mid_q;
	logic [SW-1:0]     cnt_m1, diff, mid_c, nb_c;
	logic [IDX_W-1:0]  first_q, last_q, hit_idx;
	logic [IDX_W-1:0]  first_out_q, last_out_q;
	logic [31:0]       mid32;
	logic [DATA_W-1:0] rd_mid, rd_nb;
	logic              eq, lt, stop, go_low;

	assign full   = (count_q == CW'(DEPTH));
	assign cnt_m1 = SW'(count_q) - SW'(1);
	assign diff   = hi_q - lo_q;
	assign mid_c  = lo_q + (diff >> 1);
	assign nb_c   = cmd.side ? (mid_c + SW'(1)) : (mid_c - SW'(1));

	srs_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (cmd.append && !full),
		.waddr   (count_q[AW-1:0]),
		.wdata   (value),
		.raddr_a (mid_c[AW-1:0]),
		.raddr_b (nb_c[AW-1:0]),
		.rdata_a (rd_mid),
		.rdata_b (rd_nb)
	);

	assign eq = (rd_mid == key_q);
	assign lt = $signed(key_q) < $signed(rd_mid);
	always_comb begin
		if (!cmd.side) begin
			stop = (mid_q == '0) || ($signed(rd_nb) < $signed(rd_mid));
		end else begin
			stop = (mid_q == cnt_m1) || ($signed(rd_nb) > $signed(rd_mid));
		end
	end
	assign go_low = (eq && !cmd.side) || lt;

	assign stat.run = $signed(lo_q) <= $signed(hi_q);
	assign stat.hit = eq && stop;

	assign mid32   = 32'(mid_q);
	assign hit_idx = mid32[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.append && !full) begin
			count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_key) begin
			key_q <= value;
		end
		if (cmd.init) begin
			lo_q <= '0;
			hi_q <= cnt_m1;
		end else if (cmd.step) begin
			if (go_low) begin
				hi_q <= mid_q - SW'(1);
			end else begin
				lo_q <= mid_q + SW'(1);
			end
		end
		if (cmd.probe) begin
			mid_q <= mid_c;
		end
		if (cmd.rec_hit || cmd.rec_miss) begin
			if (!cmd.side) begin
				first_q <= cmd.rec_hit ? hit_idx : IDX_NONE;
			end else begin
				last_q <= cmd.rec_hit ? hit_idx : IDX_NONE;
			end
		end
		if (cmd.load_out) begin
			first_out_q <= first_q;
			last_out_q  <= last_q;
		end
	end

	assign first_index = first_out_q;
	assign last_index  = last_out_q;

endmodule

>>> rtl/sorted_range_search_core.sv
// Sorted range search. Values are appended in non-decreasing order into a
// DEPTH-entry RAM (appends past DEPTH are dropped, a clear empties it). A
// query runs a lower-bound and an upper-bound binary search and returns the
// first and last index holding the key, or -1 (all ones) for both if absent.
// Clear and append are taken in idle and may be sent back to back. A query
// holds off the input while it runs; each probe is one registered read of the
// RAM (entry and neighbor together) followed by one compare, and each search
// ends early on a match at the boundary.
// The output is registered; input transfers continue while a result waits.
module sorted_range_search_core
	import srs_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [OP_W-1:0]          op,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [IDX_W-1:0]  first_index,
	output logic signed [IDX_W-1:0]  last_index
);

	cmd_t  cmd;
	stat_t stat;

	srs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	srs_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.value       (value),
		.first_index (first_index),
		.last_index  (last_index)
	);

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == OP_QUERY) |=> !in_ready)
		else $error("input ready right after query transfer");

	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a query in progress");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear, cmd.append, cmd.load_key, cmd.probe, cmd.step,
			cmd.load_out}))
		else $error("conflicting datapath commands");

endmodule
